/* rtl/iplm_pkg.sv */
// Shared types, constants and codes for the interrupt priority mask unit.
package iplm_pkg;

    localparam int NUM_VECTORS_DEF = 96;
    localparam int NUM_LEVELS_DEF  = 8;
    localparam int WORD_W          = 32;
    localparam logic [4:0] BIT_SEL = 5'h1f;
    localparam logic [6:0] VEC_SEL = 7'h7f;

    typedef enum logic [1:0] {
        FUNC_UNMASK = 2'd0,
        FUNC_MASK   = 2'd1,
        FUNC_ENTER  = 2'd2,
        FUNC_EXIT   = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_READ,
        S_UPDATE,
        S_ROWS,
        S_EMIT,
        S_FLAG
    } t_state;

    typedef struct packed {
        logic load_item;
        logic read_lvl;
        logic set_lim;
        logic row_step;
        logic write_lvl;
        logic clear_lvl;
        logic set_active_enter;
        logic set_active_exit;
        logic emit_word;
        logic emit_flag;
    } t_cmd;

    typedef struct packed {
        t_func func;
        logic  spurious;
        logic  rows_done;
        logic  words_last;
        logic  out_free;
    } t_sts;

endpackage

/* rtl/iplm_ctrl.sv */
// Sequencer for the interrupt priority mask unit.
module iplm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  iplm_pkg::t_sts i_sts,
    output iplm_pkg::t_cmd o_cmd
);
    import iplm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                if (i_sts.spurious) begin
                    n_state = S_FLAG;
                end else begin
                    case (i_sts.func)
                        FUNC_UNMASK: n_state = S_ROWS;
                        FUNC_MASK:   n_state = S_READ;
                        FUNC_ENTER:  n_state = S_READ;
                        default:     n_state = S_UPDATE;
                    endcase
                end
            end
            S_READ:   n_state = S_UPDATE;
            S_UPDATE: begin
                if (i_sts.func == FUNC_MASK) n_state = S_ROWS;
                else n_state = S_EMIT;
            end
            S_ROWS: begin
                if (i_sts.rows_done) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free && i_sts.words_last) n_state = S_IDLE;
            end
            S_FLAG: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.load_item = i_in_valid;
            end
            S_READ: o_cmd.read_lvl = 1'b1;
            S_UPDATE: begin
                case (i_sts.func)
                    FUNC_MASK:  o_cmd.set_lim          = 1'b1;
                    FUNC_ENTER: o_cmd.set_active_enter = 1'b1;
                    FUNC_EXIT:  o_cmd.set_active_exit  = 1'b1;
                    default:    o_cmd.set_lim          = 1'b0;
                endcase
            end
            S_ROWS: begin
                if (!i_sts.rows_done) begin
                    o_cmd.row_step = 1'b1;
                end else if (i_sts.func == FUNC_UNMASK) begin
                    o_cmd.write_lvl = 1'b1;
                end else begin
                    o_cmd.clear_lvl = 1'b1;
                end
            end
            S_EMIT: o_cmd.emit_word = i_sts.out_free;
            S_FLAG: o_cmd.emit_flag = i_sts.out_free;
            default: o_in_ready = 1'b0;
        endcase
    end

endmodule

/* rtl/iplm_dp.sv */
// Datapath: level memory, enable word table, current level and result register.
module iplm_dp #(
    parameter int NUM_VECTORS = iplm_pkg::NUM_VECTORS_DEF,
    parameter int NUM_LEVELS  = iplm_pkg::NUM_LEVELS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [1:0]                  i_func,
    input  logic [6:0]                  i_vector,
    input  logic [2:0]                  i_level,
    input  iplm_pkg::t_cmd              i_cmd,
    output iplm_pkg::t_sts              o_sts,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [1:0]                  o_word_index,
    output logic [iplm_pkg::WORD_W-1:0] o_mask_word,
    output logic                        o_last,
    output logic                        o_ignored,
    output logic [2:0]                  o_previous_level,
    output logic [2:0]                  o_current_level,
    output logic [6:0]                  o_served_vector
);
    import iplm_pkg::*;

    localparam int NUM_WORDS = (NUM_VECTORS + 31) / 32;
    localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int LIDX_W    = $clog2(NUM_LEVELS);
    localparam int VIDX_W    = $clog2(NUM_VECTORS);

    // latched item
    t_func        r_func;
    logic [6:0]   r_vec;
    logic [2:0]   r_level;
    logic [2:0]   r_prev;
    logic [2:0]   r_active;
    logic [2:0]   r_lim;
    logic [2:0]   r_idx;
    logic [WIDX_W-1:0] r_wcnt;

    // per-vector level store
    logic [2:0]             r_vlvl_mem [NUM_VECTORS];
    logic [NUM_VECTORS-1:0] r_vlvl_vld;
    logic [2:0]             r_rd;
    logic                   r_rd_vld;

    logic [WORD_W-1:0] r_rows [NUM_LEVELS][NUM_WORDS];

    logic                r_out_valid;
    logic [1:0]          r_out_index;
    logic [WORD_W-1:0]   r_out_word;
    logic                r_out_last;
    logic                r_out_ignored;
    logic [2:0]          r_out_prev;
    logic [2:0]          r_out_cur;
    logic [6:0]          r_out_vec;

    logic [VIDX_W-1:0]   vaddr;
    logic [WIDX_W-1:0]   widx;
    logic [WORD_W-1:0]   bit_sel;
    logic [2:0]          lvl_rd;
    logic [2:0]          lvl_clamped;
    logic [2:0]          lvl_sat;
    logic [LIDX_W-1:0]   row_lvl;
    logic [WIDX_W-1:0]   row_word;
    logic [WORD_W-1:0]   row_rd;
    logic                out_free;

    assign vaddr   = r_vec[VIDX_W-1:0];
    assign widx    = r_vec[5 +: WIDX_W];
    assign bit_sel = WORD_W'(1) << (r_vec[4:0] & BIT_SEL);
    assign lvl_rd  = r_rd_vld ? r_rd : 3'd0;

    assign lvl_clamped = ({1'b0, r_level} >= 4'(NUM_LEVELS)) ? 3'(NUM_LEVELS - 1) : r_level;
    assign lvl_sat     = ({1'b0, lvl_rd} >= 4'(NUM_LEVELS)) ? 3'(NUM_LEVELS - 1) : lvl_rd;

    // one table read port: row walk or word emit
    assign row_lvl  = i_cmd.row_step ? r_idx[LIDX_W-1:0] : r_active[LIDX_W-1:0];
    assign row_word = i_cmd.row_step ? widx : r_wcnt;
    assign row_rd   = r_rows[row_lvl][row_word];

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_sts            = '0;
        o_sts.func       = r_func;
        o_sts.spurious   = (r_func != FUNC_EXIT) && ({1'b0, r_vec} >= 8'(NUM_VECTORS));
        o_sts.rows_done  = (r_idx == r_lim);
        o_sts.words_last = (r_wcnt == WIDX_W'(NUM_WORDS - 1));
        o_sts.out_free   = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_func  <= t_func'(i_func);
            r_vec   <= i_vector & VEC_SEL;
            r_level <= i_level;
            r_prev  <= r_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim  <= '0;
            r_idx  <= '0;
            r_wcnt <= '0;
        end else begin
            if (i_cmd.load_item) begin
                r_idx  <= '0;
                r_wcnt <= '0;
                // unmask walks the rows below the requested level
                r_lim  <= ({1'b0, i_level} >= 4'(NUM_LEVELS)) ? 3'(NUM_LEVELS - 1) : i_level;
            end
            if (i_cmd.set_lim) r_lim <= lvl_sat;
            if (i_cmd.row_step) r_idx <= r_idx + 3'd1;
            if (i_cmd.emit_word) begin
                r_wcnt <= o_sts.words_last ? '0 : r_wcnt + WIDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (i_cmd.set_active_enter) begin
            if (lvl_rd > r_active) r_active <= lvl_rd;
        end else if (i_cmd.set_active_exit) begin
            r_active <= lvl_clamped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_lvl) r_vlvl_mem[vaddr] <= r_lim;
        if (i_cmd.read_lvl) r_rd <= r_vlvl_mem[vaddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vlvl_vld <= '0;
            r_rd_vld   <= 1'b0;
        end else begin
            if (i_cmd.write_lvl) r_vlvl_vld[vaddr] <= 1'b1;
            if (i_cmd.clear_lvl) r_vlvl_vld[vaddr] <= 1'b0;
            if (i_cmd.read_lvl) r_rd_vld <= r_vlvl_vld[vaddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < NUM_LEVELS; l++) begin
                for (int w = 0; w < NUM_WORDS; w++) begin
                    r_rows[l][w] <= '0;
                end
            end
        end else if (i_cmd.row_step) begin
            if (r_func == FUNC_UNMASK) r_rows[row_lvl][row_word] <= row_rd | bit_sel;
            else r_rows[row_lvl][row_word] <= row_rd & ~bit_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_word || i_cmd.emit_flag) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_word) begin
            r_out_index   <= 2'(r_wcnt);
            r_out_word    <= ~row_rd;
            r_out_last    <= o_sts.words_last;
            r_out_ignored <= 1'b0;
            r_out_prev    <= r_prev;
            r_out_cur     <= r_active;
            r_out_vec     <= r_vec;
        end else if (i_cmd.emit_flag) begin
            r_out_index   <= '0;
            r_out_word    <= '0;
            r_out_last    <= 1'b1;
            r_out_ignored <= 1'b1;
            r_out_prev    <= r_active;
            r_out_cur     <= r_active;
            r_out_vec     <= r_vec;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_word_index     = r_out_index;
    assign o_mask_word      = r_out_word;
    assign o_last           = r_out_last;
    assign o_ignored        = r_out_ignored;
    assign o_previous_level = r_out_prev;
    assign o_current_level  = r_out_cur;
    assign o_served_vector  = r_out_vec;

    a_flag_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_ignored |-> r_out_last && (r_out_word == '0))
        else $error("flagged item not a single zero word");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.row_step |-> (r_idx < r_lim))
        else $error("row walk past its level limit");

    a_active_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_active} < 4'(NUM_LEVELS))
        else $error("current level out of range");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_word || i_cmd.emit_flag) |-> out_free)
        else $error("result register overwritten");

endmodule

/* rtl/interrupt_priority_mask_unit.sv */
// Top level of the interrupt priority mask unit: sequencer plus datapath.
//
//  channel | direction | handshake                    | payload
//  in      | input     | i_in_valid / o_in_ready      | i_func, i_vector, i_level
//  out     | output    | o_out_valid / i_out_ready    | o_word_index, o_mask_word, o_last,
//          |           |                              | o_ignored, o_previous_level,
//          |           |                              | o_current_level, o_served_vector
//
// One item at a time. Unmask walks the enable table rows below its level; mask reads the
// vector's level and walks the rows below it; enter raises and exit sets the current level.
// Then the mask words go out. One enable table row is updated per cycle, one mask word sent
// per cycle while the output is not stalled. Spurious items (vector out of range, not exit)
// give a flagged result. The level memory has one read port with registered data.
// Reset is synchronous; state is usable the cycle after reset, with no clearing pass.
// A stalled output holds the result register; the next item is taken once the last
// result of the current one sits in that register.
module interrupt_priority_mask_unit #(
    parameter int NUM_VECTORS = iplm_pkg::NUM_VECTORS_DEF,
    parameter int NUM_LEVELS  = iplm_pkg::NUM_LEVELS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_func,
    input  logic [6:0]                  i_vector,
    input  logic [2:0]                  i_level,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [1:0]                  o_word_index,
    output logic [iplm_pkg::WORD_W-1:0] o_mask_word,
    output logic                        o_last,
    output logic                        o_ignored,
    output logic [2:0]                  o_previous_level,
    output logic [2:0]                  o_current_level,
    output logic [6:0]                  o_served_vector
);
    import iplm_pkg::*;

    t_cmd cmd;
    t_sts sts;

    iplm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    iplm_dp #(
        .NUM_VECTORS (NUM_VECTORS),
        .NUM_LEVELS  (NUM_LEVELS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_func           (i_func),
        .i_vector         (i_vector),
        .i_level          (i_level),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_word_index     (o_word_index),
        .o_mask_word      (o_mask_word),
        .o_last           (o_last),
        .o_ignored        (o_ignored),
        .o_previous_level (o_previous_level),
        .o_current_level  (o_current_level),
        .o_served_vector  (o_served_vector)
    );

endmodule
